// ===== src/nsr_pkg.sv =====
// Package with shared constants for the Newton square-root core.
`timescale 1ns / 1ps
package nsr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;

	localparam int ADDR_BITS = 4;

	localparam logic [7:0]  WARMUP_RESET = 8'd16;
	localparam logic [7:0]  REFINE_RESET = 8'd100;
	localparam logic [15:0] TOL_RESET    = 16'd1;

	localparam logic [1:0] REG_WARMUP = 2'd0;
	localparam logic [1:0] REG_REFINE = 2'd1;
	localparam logic [1:0] REG_TOL    = 2'd2;

	localparam logic OP_FIXED = 1'b0;
	localparam logic OP_AUTO  = 1'b1;

endpackage

// ===== src/newton_square_root_core.sv =====
// Top level of the Newton-Raphson square-root core with its register port.
`timescale 1ns / 1ps
// A zero radicand answers in the cycle after the request is taken. Otherwise each
// Newton step runs a bit-serial square and a one-bit-per-cycle restoring divide,
// with entry and exit states around them.
// Throughput: one request at a time; busy stays high until the result strobe.
// Reset: arst_n clears control and restores warmup 16, refine limit 100, tolerance 1.
// The result stands for one cycle with done high; the receiver cannot stall it.
module newton_square_root_core #(
	parameter int WORD_BITS = nsr_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Register port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nsr_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// Request side.
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [WORD_BITS-1:0]          radicand,
	input  logic [WORD_BITS-1:0]          start_value,
	input  logic [7:0]                    step_count,
	// Result side.
	output logic                          done,
	output logic [WORD_BITS-1:0]          root,
	output logic [8:0]                    steps_done,
	output logic                          zero_divide,
	output logic                          converged
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_DONE  = 4'b1000
	} core_state_t;

	core_state_t state_q;

	logic [7:0]  warmup_q;
	logic [7:0]  refine_q;
	logic [15:0] tol_q;

	logic                 op_q;
	logic                 in_refine_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] x_q;
	logic [7:0]           remain_q;
	logic [8:0]           steps_q;
	logic                 zdiv_q;
	logic                 conv_q;

	logic                 accept;
	logic                 cfg_write;
	logic                 step_go;
	logic                 step_done;
	logic [WORD_BITS-1:0] step_nx;
	logic [WORD_BITS-1:0] step_diff;

	// The register port never waits; a write lands on the access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= nsr_pkg::WARMUP_RESET;
			refine_q <= nsr_pkg::REFINE_RESET;
			tol_q    <= nsr_pkg::TOL_RESET;
		end else if (cfg_write) begin
			case (paddr[3:2])
				nsr_pkg::REG_WARMUP: warmup_q <= pwdata[7:0];
				nsr_pkg::REG_REFINE: refine_q <= pwdata[7:0];
				nsr_pkg::REG_TOL:    tol_q    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			nsr_pkg::REG_WARMUP: prdata = {24'd0, warmup_q};
			nsr_pkg::REG_REFINE: prdata = {24'd0, refine_q};
			nsr_pkg::REG_TOL:    prdata = {16'd0, tol_q};
			default:             prdata = 32'd0;
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// A step is launched only from the check state, after the step budget and the
	// zero-iterate test have passed.
	assign step_go = (state_q == ST_CHECK) && (remain_q != 8'd0) && (x_q != '0);

	nsr_step_unit #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (step_go),
		.a      (a_q),
		.x      (x_q),
		.done   (step_done),
		.nx     (step_nx),
		.diff   (step_diff)
	);

	// Sequencer: the fixed mode runs up to step_count steps; the automatic mode runs the
	// warm-up budget, then the refine budget with the tolerance test; a zero iterate stops either.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (radicand == '0) ? ST_DONE : ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (remain_q == 8'd0) begin
						if (!(op_q == nsr_pkg::OP_AUTO && !in_refine_q)) begin
							state_q <= ST_DONE;
						end
					end else if (x_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_done) begin
						if (op_q == nsr_pkg::OP_AUTO && in_refine_q &&
							step_diff < WORD_BITS'(tol_q)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q        <= op;
					a_q         <= radicand;
					in_refine_q <= 1'b0;
					steps_q     <= '0;
					zdiv_q      <= 1'b0;
					if (radicand == '0) begin
						x_q    <= '0;
						conv_q <= op;
					end else begin
						conv_q <= 1'b0;
						if (op == nsr_pkg::OP_AUTO) begin
							x_q      <= radicand;
							remain_q <= warmup_q;
						end else begin
							x_q      <= start_value;
							remain_q <= step_count;
						end
					end
				end
			end
			ST_CHECK: begin
				if (remain_q == 8'd0) begin
					if (op_q == nsr_pkg::OP_AUTO && !in_refine_q) begin
						in_refine_q <= 1'b1;
						remain_q    <= refine_q;
					end
				end else if (x_q == '0) begin
					zdiv_q <= 1'b1;
					conv_q <= 1'b0;
				end
			end
			ST_RUN: begin
				if (step_done) begin
					x_q      <= step_nx;
					steps_q  <= steps_q + 1'b1;
					remain_q <= remain_q - 1'b1;
					if (op_q == nsr_pkg::OP_AUTO && in_refine_q &&
						step_diff < WORD_BITS'(tol_q)) begin
						conv_q <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// The result request is shown for the single done cycle.
	assign done        = (state_q == ST_DONE);
	assign root        = x_q;
	assign steps_done  = steps_q;
	assign zero_divide = zdiv_q;
	assign converged   = conv_q;

	// A result is only ever shown while a request is in flight.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without a request in flight");

	// After the result the core is free for the next request.
	a_free_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("core still busy after the result");

	// A step never starts on a zero iterate.
	a_no_zero_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_go |-> (x_q != '0))
		else $error("Newton step launched with a zero iterate");

	// A flagged zero divide always reports a zero root and no convergence.
	a_zdiv_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_divide) |-> (root == '0 && !converged))
		else $error("zero divide result is not cleared");

endmodule

// ===== src/nsr_step_unit.sv =====
// One Newton step: bit-serial square, align and subtract, bit-serial divide, update.
`timescale 1ns / 1ps
module nsr_step_unit #(
	parameter int WORD_BITS = nsr_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] x,
	output logic                 done,
	output logic [WORD_BITS-1:0] nx,
	output logic [WORD_BITS-1:0] diff
);

	localparam int W  = WORD_BITS;
	localparam int CW = $clog2(2 * W);

	typedef enum logic [4:0] {
		SU_IDLE = 5'b00001,
		SU_MUL  = 5'b00010,
		SU_SUB  = 5'b00100,
		SU_DIV  = 5'b01000,
		SU_UPD  = 5'b10000
	} su_state_t;

	su_state_t state_q;
	logic [CW-1:0]  cnt_q;
	logic [W-1:0]   mcand_q;
	logic [W-1:0]   mplr_q;
	logic [2*W-1:0] acc_q;
	logic [2*W-1:0] mag_q;
	logic           above_q;
	logic [W-1:0]   rem_q;
	logic [W:0]     quo_q;
	logic           ovf_q;

	logic [2*W-1:0] aligned;
	logic [W:0]     trial;
	logic           fits;
	logic [W-1:0]   q2;
	logic [W:0]     sum;

	assign aligned = (2 * W)'(a) << FRAC_BITS;
	assign trial   = {rem_q, mag_q[2*W-1]};
	assign fits    = trial >= {1'b0, mcand_q};

	// Quotient of the magnitude by 2x, saturated to the word.
	assign q2  = ovf_q ? {W{1'b1}} : quo_q[W:1];
	assign sum = {1'b0, mcand_q} + {1'b0, q2};

	always_comb begin
		if (above_q) begin
			nx   = mcand_q - q2;
			diff = q2;
		end else if (sum[W]) begin
			nx   = {W{1'b1}};
			diff = ~mcand_q;
		end else begin
			nx   = sum[W-1:0];
			diff = q2;
		end
	end

	assign done = (state_q == SU_UPD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SU_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				SU_IDLE: begin
					if (go) begin
						state_q <= SU_MUL;
						cnt_q   <= '0;
					end
				end
				SU_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(W - 1)) begin
						state_q <= SU_SUB;
					end
				end
				SU_SUB: begin
					cnt_q   <= '0;
					state_q <= SU_DIV;
				end
				SU_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(2 * W - 1)) begin
						state_q <= SU_UPD;
					end
				end
				SU_UPD: begin
					state_q <= SU_IDLE;
				end
				default: begin
					state_q <= SU_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SU_IDLE: begin
				if (go) begin
					mcand_q <= x;
					mplr_q  <= x;
					acc_q   <= '0;
				end
			end
			SU_MUL: begin
				acc_q  <= (acc_q << 1) + (mplr_q[W-1] ? (2 * W)'(mcand_q) : '0);
				mplr_q <= mplr_q << 1;
			end
			SU_SUB: begin
				above_q <= acc_q >= aligned;
				mag_q   <= (acc_q >= aligned) ? acc_q - aligned : aligned - acc_q;
				rem_q   <= '0;
				quo_q   <= '0;
				ovf_q   <= 1'b0;
			end
			SU_DIV: begin
				rem_q <= fits ? W'(trial - {1'b0, mcand_q}) : trial[W-1:0];
				quo_q <= {quo_q[W-1:0], fits};
				ovf_q <= ovf_q | quo_q[W];
				mag_q <= mag_q << 1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/sv/newton_square_root_checker.sv =====
// Checker for the Newton square-root core: predicts each result and compares it.
`timescale 1ns / 1ps
module newton_square_root_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [nsr_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          op,
	input  logic [31:0]                   radicand,
	input  logic [31:0]                   start_value,
	input  logic [7:0]                    step_count,
	input  logic                          done,
	input  logic [31:0]                   root,
	input  logic [8:0]                    steps_done,
	input  logic                          zero_divide,
	input  logic                          converged,
	output int                            pending,
	output int                            failures
);
	import nsr_pkg::*;

	localparam logic [31:0] ROOT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] root;
		logic [8:0]  steps;
		logic        zdiv;
		logic        conv;
	} sqrt_result_t;

	logic [7:0]   warmup_q;
	logic [7:0]   refine_q;
	logic [15:0]  tol_q;
	sqrt_result_t root_queue[$];

	assign pending = root_queue.size();

	// One exact Newton step; x must be nonzero.
	function automatic logic [31:0] newton_iterate(logic [31:0] a, logic [31:0] x);
		logic [127:0] sq;
		logic [127:0] aligned;
		logic [127:0] mag;
		logic [127:0] q;
		logic         above;
		sq = {96'b0, x} * {96'b0, x};
		aligned = {96'b0, a} << FRAC_BITS_DEF;
		above = sq >= aligned;
		mag = above ? sq - aligned : aligned - sq;
		q = (mag / {96'b0, x}) >> 1;
		if (q > {96'b0, ROOT_MAX})
			q = {96'b0, ROOT_MAX};
		if (above)
			return x - q[31:0];
		if (q[31:0] > ROOT_MAX - x)
			return ROOT_MAX;
		return x + q[31:0];
	endfunction

	function automatic sqrt_result_t predict_root(logic mode, logic [31:0] a,
			logic [31:0] x0, logic [7:0] n);
		sqrt_result_t r;
		logic [31:0]  x;
		logic [31:0]  nx;
		logic [31:0]  diff;
		int           steps;
		logic         zdiv;
		logic         conv;
		x = x0;
		steps = 0;
		zdiv = 1'b0;
		conv = 1'b0;
		if (a == 0) begin
			x = 0;
			conv = (mode == OP_AUTO);
		end else if (mode == OP_FIXED) begin
			for (int i = 0; i < n; i++) begin
				if (x == 0) begin
					zdiv = 1'b1;
					break;
				end
				x = newton_iterate(a, x);
				steps++;
			end
		end else begin
			x = a;
			for (int i = 0; i < warmup_q; i++) begin
				if (x == 0) begin
					zdiv = 1'b1;
					break;
				end
				x = newton_iterate(a, x);
				steps++;
			end
			if (!zdiv) begin
				for (int i = 0; i < refine_q; i++) begin
					if (x == 0) begin
						zdiv = 1'b1;
						break;
					end
					nx = newton_iterate(a, x);
					steps++;
					diff = (nx > x) ? nx - x : x - nx;
					x = nx;
					if (diff < {16'b0, tol_q}) begin
						conv = 1'b1;
						break;
					end
				end
			end
		end
		if (zdiv) begin
			x = 0;
			conv = 1'b0;
		end
		r.root = x;
		r.steps = steps[8:0];
		r.zdiv = zdiv;
		r.conv = conv;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		sqrt_result_t expd;
		if (!arst_n) begin
			warmup_q <= WARMUP_RESET;
			refine_q <= REFINE_RESET;
			tol_q <= TOL_RESET;
			failures <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_WARMUP: warmup_q <= pwdata[7:0];
					REG_REFINE: refine_q <= pwdata[7:0];
					REG_TOL:    tol_q <= pwdata[15:0];
					default: ;
				endcase
			end
			if (start && !busy)
				root_queue.push_back(predict_root(op, radicand, start_value, step_count));
			if (done) begin
				if (root_queue.size() == 0) begin
					$display("%0t: result with none expected: root %h steps %0d",
						$time, root, steps_done);
					failures <= failures + 1;
				end else begin
					expd = root_queue.pop_front();
					if (expd != {root, steps_done, zero_divide, converged}) begin
						$display("%0t: mismatch root exp %h act %h, steps exp %0d act %0d",
							$time, expd.root, root, expd.steps, steps_done);
						$display("%0t:   zero_divide exp %b act %b, converged exp %b act %b",
							$time, expd.zdiv, zero_divide, expd.conv, converged);
						failures <= failures + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/sv/newton_square_root_core_test.sv =====
// Top of the Newton square-root core testbench: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module newton_square_root_core_test;
	import nsr_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 start;
	logic                 busy;
	logic                 op;
	logic [31:0]          radicand;
	logic [31:0]          start_value;
	logic [7:0]           step_count;
	logic                 done;
	logic [31:0]          root;
	logic [8:0]           steps_done;
	logic                 zero_divide;
	logic                 converged;
	int                   pending;
	int                   failures;
	int                   idle_pct;

	newton_square_root_core DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .op(op), .radicand(radicand),
		.start_value(start_value), .step_count(step_count),
		.done(done), .root(root), .steps_done(steps_done),
		.zero_divide(zero_divide), .converged(converged)
	);

	newton_square_root_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.start(start), .busy(busy), .op(op), .radicand(radicand),
		.start_value(start_value), .step_count(step_count),
		.done(done), .root(root), .steps_done(steps_done),
		.zero_divide(zero_divide), .converged(converged),
		.pending(pending), .failures(failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A request runs at most 510 Newton steps; the time limit sits well above what
	// the whole run needs.
	initial begin
		#200ms;
		$display("newton_square_root_core verification failed");
		$finish;
	end

	// Registers are written only while the core is idle. Every request produces
	// a result, so an empty expectation queue means the core has nothing in flight.
	task automatic write_reg(logic [1:0] index, logic [31:0] value);
		wait (pending == 0);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(logic [7:0] warmup, logic [7:0] refine, logic [15:0] tol);
		write_reg(REG_WARMUP, {24'b0, warmup});
		write_reg(REG_REFINE, {24'b0, refine});
		write_reg(REG_TOL, {16'b0, tol});
	endtask

	// Issues one request. Start stays high across back-to-back requests and is
	// only lowered when an idle gap is taken, so it is never dropped and raised
	// within one time step.
	task automatic send_request(logic mode, logic [31:0] a, logic [31:0] x, logic [7:0] n);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		start <= 1'b1;
		op <= mode;
		radicand <= a;
		start_value <= x;
		step_count <= n;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Lets the core drain, with start low, before registers change.
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
	endtask

	// Radicands spread over all magnitudes, with some zeros.
	function automatic logic [31:0] pick_radicand();
		if ($urandom_range(19) == 0)
			return 32'd0;
		return $urandom >> $urandom_range(31);
	endfunction

	// Mostly well-formed requests: automatic mode or a modest step count from a
	// plausible start, with occasional zero starts and long fixed runs.
	task automatic random_requests(int count);
		logic [31:0] a;
		logic [31:0] x;
		logic [7:0]  n;
		for (int i = 0; i < count; i++) begin
			a = pick_radicand();
			if ($urandom_range(1)) begin
				send_request(OP_AUTO, a, $urandom, 8'($urandom));
			end else begin
				case ($urandom_range(9))
					0:       x = 32'd0;
					1, 2:    x = $urandom;
					default: x = $urandom >> $urandom_range(31);
				endcase
				n = ($urandom_range(29) == 0) ? 8'($urandom_range(100, 255))
					: 8'($urandom_range(12));
				send_request(OP_FIXED, a, x, n);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		op = OP_FIXED;
		radicand = '0;
		start_value = '0;
		step_count = '0;
		idle_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the reset register values.
		send_request(OP_FIXED, 32'd0, 32'd5, 8'd3);             // zero radicand, fixed mode
		send_request(OP_AUTO, 32'd0, 32'd0, 8'd0);              // zero radicand, automatic mode
		send_request(OP_FIXED, 32'h0001_0000, 32'd0, 8'd4);     // zero start value
		send_request(OP_FIXED, 32'h0004_0000, 32'h0001_0000, 8'd0); // no steps requested
		send_request(OP_FIXED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd10);
		send_request(OP_FIXED, 32'hFFFF_FFFF, 32'd1, 8'd40);    // quotient saturates
		send_request(OP_FIXED, 32'd1, 32'hFFFF_FFFF, 8'd6);
		send_request(OP_FIXED, 32'h0002_0000, 32'h0001_0000, 8'd255);
		send_request(OP_AUTO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_request(OP_AUTO, 32'd1, 32'd0, 8'd0);
		send_request(OP_AUTO, 32'h0004_0000, 32'd0, 8'd0);
		send_request(OP_AUTO, 32'h8000_0000, 32'h5555_5555, 8'hAA);
		send_request(OP_FIXED, 32'h5555_5555, 32'hAAAA_AAAA, 8'h55);
		send_request(OP_FIXED, 32'hAAAA_AAAA, 32'h5555_5555, 8'h0F);
		drain();

		// No warm-up and no refinement: the radicand comes straight back.
		configure(8'd0, 8'd0, 16'd0);
		send_request(OP_AUTO, 32'h0009_0000, 32'd0, 8'd0);
		send_request(OP_AUTO, 32'hFFFF_FFFF, 32'd0, 8'd0);
		idle_pct = 88;
		random_requests(8);
		drain();

		// Longest warm-up, and a tolerance so wide that the first refine step stops.
		configure(8'd255, 8'd255, 16'hFFFF);
		idle_pct = 0;
		send_request(OP_AUTO, 32'hFFFF_FFFF, 32'd0, 8'd0);
		send_request(OP_AUTO, 32'd3, 32'd0, 8'd0);
		drain();

		// Zero tolerance never converges: the whole refine budget is spent.
		configure(8'd0, 8'd255, 16'd0);
		send_request(OP_AUTO, 32'h0002_0000, 32'd0, 8'd0);
		drain();

		configure(8'd4, 8'd20, 16'd0);
		idle_pct = 9;
		random_requests(20);
		drain();

		configure(WARMUP_RESET, REFINE_RESET, TOL_RESET);
		idle_pct = 0;
		random_requests(35);
		drain();

		idle_pct = 88;
		random_requests(25);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			configure(8'($urandom_range(30)), 8'($urandom_range(40)),
				($urandom_range(1)) ? 16'($urandom_range(8)) : 16'($urandom));
			case (phase)
				0:       idle_pct = 0;
				1:       idle_pct = 88;
				default: idle_pct = 9;
			endcase
			random_requests(15);
			drain();
		end

		// Everything is accepted; give the core time for any stray result.
		repeat (300) @(posedge clk);
		if (failures == 0)
			$display("newton_square_root_core verification clean");
		else
			$display("newton_square_root_core verification failed");
		$finish;
	end
endmodule

// ===== sim.f =====
src/nsr_pkg.sv
src/nsr_step_unit.sv
src/newton_square_root_core.sv
tb/sv/newton_square_root_checker.sv
tb/sv/newton_square_root_core_test.sv
